[design/bpdt_pkg.sv]
package bpdt_pkg;

  localparam int CHANNELS  = 8;
  localparam int CH_BITS   = 3;
  localparam int CNT_BITS  = 4;
  localparam int PORT_BITS = 8;
  localparam int TIME_BITS = 32;
  localparam int MAP_BITS  = CHANNELS * CH_BITS;

  // configuration register indexes
  localparam logic [1:0] CFG_INPUT_COUNT = 2'd0;
  localparam logic [1:0] CFG_PIN_MAP     = 2'd1;
  localparam logic [1:0] CFG_OUT_MASK    = 2'd2;

  localparam logic [CNT_BITS-1:0]  RST_INPUT_COUNT = 4'd8;
  localparam logic [MAP_BITS-1:0]  RST_PIN_MAP     = 24'hFAC688;
  localparam logic [PORT_BITS-1:0] RST_OUT_MASK    = 8'h00;
  localparam logic [PORT_BITS-1:0] RST_PREV_PORT   = 8'hFF;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_RELEASED = 2'd2
  } press_state_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } back_state_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]  count;     // already saturated to CHANNELS
    logic [MAP_BITS-1:0]  pin_map;
    logic [PORT_BITS-1:0] out_mask;
  } cfg_t;

  // one changed sample handed from front to back
  typedef struct packed {
    logic [PORT_BITS-1:0] prev;
    logic [PORT_BITS-1:0] sample;
    logic [TIME_BITS-1:0] now;
  } change_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[design/bpdt_front.sv]
module bpdt_front
  import bpdt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 in_accept,
  input  logic [PORT_BITS-1:0] port_value,
  input  logic [TIME_BITS-1:0] time_ms,
  output logic                 push,
  output change_t              push_data
);

  logic [PORT_BITS-1:0] prev_r;
  logic [PORT_BITS-1:0] prev_nxt;
  logic [PORT_BITS-1:0] sample;
  logic                 changed;

  assign sample  = port_value | cfg.out_mask;
  assign changed = (sample != prev_r);

  // a change with no mapped channels only moves the stored sample
  assign push = in_accept && changed && (cfg.count != '0);

  assign push_data.prev   = prev_r;
  assign push_data.sample = sample;
  assign push_data.now    = time_ms;

  always_comb begin
    prev_nxt = prev_r;
    if (in_accept) begin
      prev_nxt = sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= RST_PREV_PORT;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

[design/bpdt_queue.sv]
module bpdt_queue
  import bpdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  change_t   push_data,
  input  logic      pop,
  output change_t   head,
  output q_status_t status
);

  change_t    mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] level_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_nxt;
  logic [1:0] level_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign status.full  = (level_r == 2'd2);
  assign status.empty = (level_r == 2'd0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      level_nxt = level_r + 2'd1;
    end else if (pop && !push) begin
      level_nxt = level_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

[design/bpdt_back.sv]
module bpdt_back
  import bpdt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  change_t              head,
  input  logic                 q_empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CH_BITS-1:0]   out_channel,
  output press_state_t         out_state,
  output logic [TIME_BITS-1:0] out_duration,
  output logic                 out_last
);

  back_state_t          state_r;
  back_state_t          state_nxt;
  logic [CH_BITS-1:0]   ch_r;
  logic [CH_BITS-1:0]   ch_nxt;

  press_state_t         status_r [CHANNELS];
  logic [TIME_BITS-1:0] start_r  [CHANNELS];
  logic [TIME_BITS-1:0] held_r   [CHANNELS];

  logic                 ovalid_r;
  logic                 ovalid_nxt;
  logic [CH_BITS-1:0]   och_r;
  press_state_t         ost_r;
  logic [TIME_BITS-1:0] odur_r;
  logic                 olast_r;

  logic                 step;
  logic                 last;
  logic [CH_BITS-1:0]   pin;
  logic                 was;
  logic                 lvl;
  press_state_t         st_nxt;
  logic [TIME_BITS-1:0] start_nxt;
  logic [TIME_BITS-1:0] held_nxt;

  assign last = ({1'b0, ch_r} + 4'd1) == cfg.count;
  assign pin  = cfg.pin_map[ch_r*CH_BITS +: CH_BITS];
  assign was  = head.prev[pin];
  assign lvl  = head.sample[pin];

  always_comb begin
    st_nxt    = status_r[ch_r];
    start_nxt = start_r[ch_r];
    held_nxt  = held_r[ch_r];
    case ({was, lvl})
      2'b10: begin
        st_nxt    = ST_PRESSED;
        start_nxt = head.now;
        held_nxt  = '0;
      end
      2'b01: begin
        st_nxt   = ST_RELEASED;
        held_nxt = head.now - start_r[ch_r];
      end
      2'b11: begin
        st_nxt = ST_IDLE;
      end
      default: begin
        // held low: channel keeps its state
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (step && last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    step   = 1'b0;
    ch_nxt = ch_r;
    case (state_r)
      BK_IDLE: begin
        ch_nxt = '0;
      end
      BK_RUN: begin
        step = !ovalid_r || out_ready;
        if (step) begin
          ch_nxt = ch_r + 3'd1;
        end
      end
      default: ch_nxt = '0;
    endcase
  end

  assign pop = step && last;

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (step) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      ch_r     <= '0;
      ovalid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        status_r[i] <= ST_IDLE;
        start_r[i]  <= '0;
        held_r[i]   <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      ch_r     <= ch_nxt;
      ovalid_r <= ovalid_nxt;
      if (step) begin
        status_r[ch_r] <= st_nxt;
        start_r[ch_r]  <= start_nxt;
        held_r[ch_r]   <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      och_r   <= ch_r;
      ost_r   <= st_nxt;
      odur_r  <= held_nxt;
      olast_r <= last;
    end
  end

  assign out_valid    = ovalid_r;
  assign out_channel  = och_r;
  assign out_state    = ost_r;
  assign out_duration = odur_r;
  assign out_last     = olast_r;

endmodule

[design/button_press_duration_tracker.sv]
// Channel  Direction  Carries
// in_      sink       tdata: port_value, time_ms
// out_     source     tdata: channel, press_state, press_duration; tlast: last_of_run
// cfg_     sink       register index, write data (always ready)
//
// A changed sample gives one result per mapped channel, one per cycle unless
// out_tready holds the output, once the back end has moved from idle to run.
// An unchanged sample never enters the queue. A two-entry queue sits between
// the sampling front end and the per-channel sequencer; in_tready drops only
// when it is full. Reset is synchronous and active low.
module button_press_duration_tracker
  import bpdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] port_value, [39:8] time_ms
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [2:0] channel, [4:3] press_state,
                                  // [36:5] press_duration, [39:37] zero
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [CNT_BITS-1:0]  count_r;
  logic [MAP_BITS-1:0]  pin_map_r;
  logic [PORT_BITS-1:0] out_mask_r;
  cfg_t                 cfg;

  logic                 in_accept;
  logic                 push;
  change_t              push_data;
  logic                 pop;
  change_t              head;
  q_status_t            q_status;

  logic [CH_BITS-1:0]   o_channel;
  press_state_t         o_state;
  logic [TIME_BITS-1:0] o_duration;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= RST_INPUT_COUNT;
      pin_map_r  <= RST_PIN_MAP;
      out_mask_r <= RST_OUT_MASK;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INPUT_COUNT: count_r    <= cfg_data[CNT_BITS-1:0];
        CFG_PIN_MAP:     pin_map_r  <= cfg_data[MAP_BITS-1:0];
        CFG_OUT_MASK:    out_mask_r <= cfg_data[PORT_BITS-1:0];
        default: begin
          // unmapped index: ignored
        end
      endcase
    end
  end

  assign cfg.count    = (count_r > CNT_BITS'(CHANNELS)) ? CNT_BITS'(CHANNELS) : count_r;
  assign cfg.pin_map  = pin_map_r;
  assign cfg.out_mask = out_mask_r;

  assign in_tready = !q_status.full;
  assign in_accept = in_tvalid && in_tready;

  bpdt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_accept  (in_accept),
    .port_value (in_tdata[7:0]),
    .time_ms    (in_tdata[39:8]),
    .push       (push),
    .push_data  (push_data)
  );

  bpdt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  bpdt_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .head         (head),
    .q_empty      (q_status.empty),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_channel  (o_channel),
    .out_state    (o_state),
    .out_duration (o_duration),
    .out_last     (out_tlast)
  );

  assign out_tdata = {3'b000, o_duration, o_state, o_channel};

  // sequencer never reads or pops an empty queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("pop from empty change queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("push into full change queue");

  a_channel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, o_channel} < cfg.count))
    else $error("result for unmapped channel");

  a_last_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (({1'b0, o_channel} + 4'd1) == cfg.count))
    else $error("tlast not on final mapped channel");

endmodule

[tb/sv/tb_button_press_duration_tracker.sv]
`timescale 1ns / 100ps

module tb_button_press_duration_tracker;
  import bpdt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int RANDOM_PHASES = 6;
  localparam int SAMPLES_PER_PHASE = 13;
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  // sel/val: port and timestamp for a sample, register index and data for a write
  typedef struct packed {
    row_kind_t    kind;
    logic [7:0]   sel;
    logic [31:0]  val;
    logic         known;
    logic [2:0]   kch;
    press_state_t kst;
    logic [31:0]  kdur;
  } stim_row_t;

  typedef struct packed {
    logic [2:0]   ch;
    press_state_t st;
    logic [31:0]  dur;
    logic         last;
  } chan_report_t;

  localparam int NROWS = 29;
  localparam stim_row_t SCRIPT [NROWS] = '{
    '{ROW_ITEM, 8'hFF, 32'd5,          1'b0, 3'd0, ST_IDLE,     32'd0},
    '{ROW_ITEM, 8'hFE, 32'd100,        1'b1, 3'd0, ST_PRESSED,  32'd0},
    '{ROW_ITEM, 8'hFF, 32'd350,        1'b1, 3'd0, ST_RELEASED, 32'd250},
    '{ROW_ITEM, 8'h00, 32'hFFFFFFF0,   1'b1, 3'd7, ST_PRESSED,  32'd0},
    '{ROW_ITEM, 8'hFF, 32'h0000000F,   1'b1, 3'd7, ST_RELEASED, 32'h1F},
    // idle channel keeps reporting its last held time
    '{ROW_ITEM, 8'h7F, 32'd1000,       1'b1, 3'd0, ST_IDLE,     32'h1F},
    // pin 7 stays low: channel 7 untouched
    '{ROW_ITEM, 8'h7E, 32'd1500,       1'b1, 3'd7, ST_PRESSED,  32'd0},
    '{ROW_ITEM, 8'h7E, 32'd1600,       1'b0, 3'd0, ST_IDLE,     32'd0},
    '{ROW_ITEM, 8'hFF, 32'hFFFFFFFF,   1'b0, 3'd0, ST_IDLE,     32'd0},
    '{ROW_ITEM, 8'h55, 32'd0,          1'b0, 3'd0, ST_IDLE,     32'd0},
    '{ROW_ITEM, 8'hAA, 32'hFFFFFFFF,   1'b0, 3'd0, ST_IDLE,     32'd0},
    '{ROW_ITEM, 8'h00, 32'h80000000,   1'b0, 3'd0, ST_IDLE,     32'd0},
    '{ROW_ITEM, 8'hFF, 32'h7FFFFFFF,   1'b1, 3'd1, ST_RELEASED, 32'hFFFFFFFF},
    // no mapped channels: sample is tracked but nothing comes out
    '{ROW_CFG,  CFG_INPUT_COUNT, 32'd0, 1'b0, 3'd0, ST_IDLE,    32'd0},
    '{ROW_ITEM, 8'h00, 32'd20,         1'b0, 3'd0, ST_IDLE,     32'd0},
    '{ROW_ITEM, 8'hFF, 32'd30,         1'b0, 3'd0, ST_IDLE,     32'd0},
    // count above eight saturates
    '{ROW_CFG,  CFG_INPUT_COUNT, 32'd15, 1'b0, 3'd0, ST_IDLE,   32'd0},
    '{ROW_ITEM, 8'h0F, 32'd40,         1'b1, 3'd7, ST_PRESSED,  32'd0},
    // every channel shares pin 0
    '{ROW_CFG,  CFG_PIN_MAP, 32'h000000, 1'b0, 3'd0, ST_IDLE,   32'd0},
    '{ROW_ITEM, 8'hFE, 32'd50,         1'b1, 3'd5, ST_PRESSED,  32'd0},
    '{ROW_CFG,  CFG_OUT_MASK, 32'hFF,  1'b0, 3'd0, ST_IDLE,     32'd0},
    '{ROW_ITEM, 8'h00, 32'd90,         1'b1, 3'd3, ST_RELEASED, 32'd40},
    // write to an unmapped index must not disturb the mask
    '{ROW_CFG,  CFG_UNMAPPED, 32'hFFFFFF, 1'b0, 3'd0, ST_IDLE,  32'd0},
    '{ROW_ITEM, 8'h12, 32'd100,        1'b0, 3'd0, ST_IDLE,     32'd0},
    '{ROW_CFG,  CFG_PIN_MAP, 32'hFFFFFF, 1'b0, 3'd0, ST_IDLE,   32'd0},
    '{ROW_CFG,  CFG_OUT_MASK, 32'h00,  1'b0, 3'd0, ST_IDLE,     32'd0},
    '{ROW_CFG,  CFG_INPUT_COUNT, 32'd1, 1'b0, 3'd0, ST_IDLE,    32'd0},
    '{ROW_ITEM, 8'h7F, 32'd200,        1'b1, 3'd0, ST_PRESSED,  32'd0},
    '{ROW_ITEM, 8'hFF, 32'd0,          1'b1, 3'd0, ST_RELEASED, 32'hFFFFFF38}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;    // [7:0] port_value, [39:8] time_ms
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // [2:0] channel, [4:3] press_state,
                                 // [36:5] press_duration, [39:37] zero
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  button_press_duration_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // tracker state as seen from outside
  logic [3:0]   cnt      = RST_INPUT_COUNT;
  logic [23:0]  pin_map  = RST_PIN_MAP;
  logic [7:0]   out_mask = RST_OUT_MASK;
  logic [7:0]   last_sample = RST_PREV_PORT;
  press_state_t ch_state [CHANNELS] = '{default: ST_IDLE};
  logic [31:0]  ch_start [CHANNELS] = '{default: '0};
  logic [31:0]  ch_held  [CHANNELS] = '{default: '0};

  chan_report_t reports_due [$];
  stim_row_t    hint = '0;
  bit           bad = 1'b0;
  int           snd_idle = 30;
  int           rcv_idle = 74;
  int unsigned  cycles = 0;

  function automatic void track_sample(input logic [7:0] raw, input logic [31:0] stamp);
    logic [7:0]   smp;
    int           n;
    logic [2:0]   pin;
    logic         was;
    logic         lvl;
    chan_report_t r;
    smp = raw | out_mask;
    if (smp == last_sample) return;
    n = (cnt > CHANNELS) ? CHANNELS : int'(cnt);
    for (int i = 0; i < n; i++) begin
      pin = pin_map[3*i +: 3];
      was = last_sample[pin];
      lvl = smp[pin];
      if (was && !lvl) begin
        ch_start[i] = stamp;
        ch_state[i] = ST_PRESSED;
        ch_held[i]  = '0;
      end else if (!was && lvl) begin
        ch_state[i] = ST_RELEASED;
        ch_held[i]  = stamp - ch_start[i];
      end else if (was && lvl) begin
        ch_state[i] = ST_IDLE;
      end
      r.ch   = 3'(i);
      r.st   = ch_state[i];
      r.dur  = ch_held[i];
      r.last = (i + 1 == n);
      if (hint.known && hint.kch == 3'(i)) begin
        r.st  = hint.kst;
        r.dur = hint.kdur;
      end
      reports_due.push_back(r);
    end
    last_sample = smp;
  endfunction

  // results are checked before the same edge's sample is tracked
  always @(posedge clk) begin : monitor
    chan_report_t got;
    chan_report_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.ch   = out_tdata[2:0];
        got.st   = press_state_t'(out_tdata[4:3]);
        got.dur  = out_tdata[36:5];
        got.last = out_tlast;
        if (reports_due.size() == 0) begin
          $error("unexpected result for channel %0d", got.ch);
          bad = 1'b1;
        end else begin
          want = reports_due.pop_front();
          if (got.ch != want.ch) begin
            $error("channel: expected %0d, got %0d", want.ch, got.ch);
            bad = 1'b1;
          end
          if (got.st != want.st) begin
            $error("press_state: expected %0d, got %0d", want.st, got.st);
            bad = 1'b1;
          end
          if (got.dur != want.dur) begin
            $error("press_duration: expected %0h, got %0h", want.dur, got.dur);
            bad = 1'b1;
          end
          if (got.last != want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, got.last);
            bad = 1'b1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INPUT_COUNT: cnt      = cfg_data[3:0];
          CFG_PIN_MAP:     pin_map  = cfg_data;
          CFG_OUT_MASK:    out_mask = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) track_sample(in_tdata[7:0], in_tdata[39:8]);
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[button_press_duration_tracker] ERROR");
      $finish;
    end
  end

  // all tasks are entered and left at a falling edge
  task automatic push_sample(input logic [7:0] port, input logic [31:0] stamp);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {stamp, port};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // drain: a sample with no results may still be in flight after the last one
  task automatic settle();
    in_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    stim_row_t   row;
    logic [7:0]  raw;
    logic [31:0] stamp;
    logic [23:0] map_val;
    logic [2:0]  pa;
    logic [2:0]  pb;
    int          pick;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (SCRIPT[k]) begin
      row = SCRIPT[k];
      if (row.kind == ROW_CFG) begin
        if (!cfg_valid) settle();
        write_reg(row.sel[1:0], row.val[23:0]);
      end else begin
        cfg_valid <= 1'b0;
        hint = row;
        push_sample(row.sel, row.val);
      end
    end

    hint  = '0;
    raw   = 8'hFF;
    stamp = 32'd5000;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 2) begin
        snd_idle = 74;
        rcv_idle = 30;
      end
      if (ph == 4) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      settle();
      case ($urandom_range(0, 3))
        0, 1: map_val = 24'($urandom);
        2:    map_val = RST_PIN_MAP;
        default: begin
          // two pins shared among all channels
          pa = 3'($urandom_range(0, 7));
          pb = 3'($urandom_range(0, 7));
          for (int c = 0; c < CHANNELS; c++)
            map_val[3*c +: 3] = $urandom_range(0, 1) ? pa : pb;
        end
      endcase
      write_reg(CFG_INPUT_COUNT, ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 15))
                                                             : 24'($urandom_range(1, 8)));
      write_reg(CFG_PIN_MAP, map_val);
      write_reg(CFG_OUT_MASK, $urandom_range(0, 1) ? 24'd0 : 24'($urandom & $urandom & 8'hFF));
      cfg_valid <= 1'b0;
      repeat (SAMPLES_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          raw = raw ^ (8'h01 << $urandom_range(0, 7));
        end else if (pick < 80) begin
          raw = raw ^ (8'h01 << $urandom_range(0, 7)) ^ (8'h01 << $urandom_range(0, 7));
        end else if (pick >= 88) begin
          raw = 8'($urandom);
        end
        if ($urandom_range(0, 19) == 0) stamp = $urandom;
        else stamp = stamp + $urandom_range(0, 3000);
        push_sample(raw, stamp);
      end
    end

    settle();
    if (!bad) begin
      $display("[button_press_duration_tracker] OK");
    end else begin
      $display("[button_press_duration_tracker] ERROR");
    end
    $finish;
  end

endmodule

[button_press_duration_tracker.f]
design/bpdt_pkg.sv
design/bpdt_front.sv
design/bpdt_queue.sv
design/bpdt_back.sv
design/button_press_duration_tracker.sv
tb/sv/tb_button_press_duration_tracker.sv
